[design/mcas_pkg.sv]
// ---------------------------------------------------------------------------
// mcas_pkg: shared types and codes of the min-cost assignment solver
// Beat structs for the command and result channels, command and status
// codes, and the default sizing of the point stores.
// ---------------------------------------------------------------------------
package mcas_pkg;

    // default sizing, handed to the top level parameters
    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 8;

    // command codes
    localparam logic [1:0] CMD_PERSON = 2'd0;
    localparam logic [1:0] CMD_HOUSE  = 2'd1;
    localparam logic [1:0] CMD_SOLVE  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // result width and saturation value
    localparam int TOTAL_W = 15;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // command beat
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] row;
        logic [7:0] col;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic [TOTAL_W-1:0] total_cost;
        logic [1:0]         status;
    } t_out_beat;

    // point store write strobes
    typedef struct packed {
        logic person_we;
        logic house_we;
    } t_load_ctl;

endpackage

[design/mcas_core.sv]
// ---------------------------------------------------------------------------
// mcas_core: labeling engine of the min-cost assignment solver
// Holds the point stores and the working stores of a solve. A small
// sequencer walks column minimum init, tight-edge depth-first search on an
// explicit stack, least-slack label update and the final label sum, one
// store access and one narrow add/compare per step.
// ---------------------------------------------------------------------------
module mcas_core #(
    parameter int MAX_POINTS = mcas_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = mcas_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mcas_pkg::t_load_ctl               i_load,
    input  logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] i_wr_addr,
    input  logic [2*COORD_BITS-1:0]           i_wr_point,
    input  logic                              i_go,
    input  logic [$clog2(MAX_POINTS+1)-1:0]   i_npts,
    output logic                              o_busy,
    output logic                              o_done,
    output logic [mcas_pkg::TOTAL_W-1:0]      o_total
);

    localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int PT_W   = 2 * COORD_BITS;
    localparam int COST_W = COORD_BITS + 1;
    localparam int LBL_W  = COORD_BITS + 4;
    localparam int SLK_W  = LBL_W + 1;
    localparam int RED_W  = LBL_W + 2;
    localparam int ACC_W0 = LBL_W + CNT_W + 1;
    localparam int ACC_W  = (ACC_W0 > 16) ? ACC_W0 : 16;
    localparam int STK_W  = 2 * IDX_W;
    localparam logic [SLK_W-1:0]  SLK_NONE = '1;
    localparam logic [COST_W-1:0] COST_TOP = '1;
    localparam logic [ACC_W-1:0]  ACC_SAT  = ACC_W'(mcas_pkg::TOTAL_MAX);

    typedef enum logic [4:0] {
        S_IDLE, S_IC_RD, S_IC_CMP, S_ROW_START, S_SC,
        S_COL_RD, S_COL_DIST, S_COL_EVAL, S_COL_NEXT,
        S_PF_RD, S_PF_WAIT, S_UW, S_UW_RD, S_UW_WR,
        S_DM_START, S_DM_RD, S_DM_CMP, S_DM_END,
        S_UP_RD, S_UP_WR, S_ROW_NEXT, S_SUM_RD, S_SUM_ACC, S_FIN
    } t_state;

    // Manhattan distance of two packed points
    function automatic logic [COST_W-1:0] f_dist(input logic [PT_W-1:0] a,
                                                 input logic [PT_W-1:0] b);
        logic [COORD_BITS-1:0] ar, ac, br, bc, dr, dc;
        ar = a[PT_W-1:COORD_BITS];
        ac = a[COORD_BITS-1:0];
        br = b[PT_W-1:COORD_BITS];
        bc = b[COORD_BITS-1:0];
        dr = (ar > br) ? ar - br : br - ar;
        dc = (ac > bc) ? ac - bc : bc - ac;
        return {1'b0, dr} + {1'b0, dc};
    endfunction

    // stores
    logic [PT_W-1:0]         m_pp  [MAX_POINTS];
    logic [PT_W-1:0]         m_hp  [MAX_POINTS];
    logic signed [LBL_W-1:0] m_rl  [MAX_POINTS];
    logic signed [LBL_W-1:0] m_cl  [MAX_POINTS];
    logic [SLK_W-1:0]        m_sl  [MAX_POINTS];
    logic [IDX_W-1:0]        m_own [MAX_POINTS];
    logic [STK_W-1:0]        m_stk [MAX_POINTS];

    logic [PT_W-1:0]         r_pp_q, r_hp_q;
    logic signed [LBL_W-1:0] r_rl_q, r_cl_q;
    logic [SLK_W-1:0]        r_sl_q;
    logic [IDX_W-1:0]        r_own_q;
    logic [STK_W-1:0]        r_stk_q;

    // sequencer registers
    t_state                  r_state;
    logic [IDX_W-1:0]        r_row, r_c, r_root, r_last;
    logic [CNT_W-1:0]        r_sp;
    logic [COST_W-1:0]       r_min, r_cost;
    logic [SLK_W-1:0]        r_d;
    logic signed [ACC_W-1:0] r_acc;
    logic [MAX_POINTS-1:0]   r_rv, r_cv, r_ov;
    logic                    r_done;
    logic [mcas_pkg::TOTAL_W-1:0] r_total;

    // combinational helpers
    logic [IDX_W-1:0]        rl_addr, own_waddr, own_wdata, stk_row, stk_col;
    logic [CNT_W-1:0]        sp_m1, last_cnt;
    logic [COST_W-1:0]       dist_now, n_min;
    logic signed [RED_W-1:0] red;
    logic                    red_pos, init_wr, upd;
    logic [SLK_W-1:0]        red_slk;
    logic signed [LBL_W-1:0] d_lbl;
    logic                    rl_we, cl_we, sl_we, own_we, stk_we;
    logic signed [LBL_W-1:0] rl_wd, cl_wd;
    logic [SLK_W-1:0]        sl_wd;

    assign sp_m1    = r_sp - 1'b1;
    assign last_cnt = i_npts - 1'b1;
    assign stk_row  = r_stk_q[STK_W-1:IDX_W];
    assign stk_col  = r_stk_q[IDX_W-1:0];
    assign dist_now = f_dist(r_pp_q, r_hp_q);
    assign n_min    = (dist_now < r_min) ? dist_now : r_min;
    assign red      = $signed({{(RED_W-COST_W){1'b0}}, r_cost})
                    - {{2{r_rl_q[LBL_W-1]}}, r_rl_q}
                    - {{2{r_cl_q[LBL_W-1]}}, r_cl_q};
    assign red_pos  = !red[RED_W-1] && (red != '0);
    assign red_slk  = red[SLK_W-1:0];
    assign d_lbl    = $signed(r_d[LBL_W-1:0]);
    assign upd      = (r_state == S_UP_RD) || (r_state == S_UP_WR)
                   || (r_state == S_SUM_RD) || (r_state == S_SUM_ACC);
    assign rl_addr  = upd ? r_c : r_row;
    assign init_wr  = (r_state == S_IC_CMP) && (r_row == r_last);

    // store write decode
    always_comb begin
        rl_we     = 1'b0;
        cl_we     = 1'b0;
        sl_we     = 1'b0;
        own_we    = 1'b0;
        stk_we    = 1'b0;
        rl_wd     = '0;
        cl_wd     = $signed({{(LBL_W-COST_W){1'b0}}, n_min});
        sl_wd     = SLK_NONE;
        own_waddr = r_c;
        own_wdata = r_row;
        if (init_wr) begin
            rl_we = 1'b1;
            cl_we = 1'b1;
        end
        if (r_state == S_SC) begin
            sl_we = 1'b1;
        end
        if (r_state == S_COL_EVAL) begin
            if (red_pos) begin
                sl_we = (red_slk < r_sl_q);
                sl_wd = red_slk;
            end else if (!r_cv[r_c]) begin
                own_we = !r_ov[r_c];
                stk_we = r_ov[r_c];
            end
        end
        if (r_state == S_UW_WR) begin
            own_we    = 1'b1;
            own_waddr = stk_col;
            own_wdata = stk_row;
        end
        if (r_state == S_UP_WR) begin
            sl_we = 1'b1;
            rl_we = r_rv[r_c];
            rl_wd = r_rl_q + d_lbl;
            cl_we = r_cv[r_c];
            cl_wd = r_cl_q - d_lbl;
        end
    end

    // point stores
    always_ff @(posedge i_clk) begin
        if (i_load.person_we) begin
            m_pp[i_wr_addr] <= i_wr_point;
        end
        if (i_load.house_we) begin
            m_hp[i_wr_addr] <= i_wr_point;
        end
        r_pp_q <= m_pp[r_row];
        r_hp_q <= m_hp[r_c];
    end

    // label, slack, owner and stack stores
    always_ff @(posedge i_clk) begin
        if (rl_we) begin
            m_rl[r_c] <= rl_wd;
        end
        if (cl_we) begin
            m_cl[r_c] <= cl_wd;
        end
        if (sl_we) begin
            m_sl[r_c] <= sl_wd;
        end
        if (own_we) begin
            m_own[own_waddr] <= own_wdata;
        end
        if (stk_we) begin
            m_stk[r_sp[IDX_W-1:0]] <= {r_row, r_c};
        end
        r_rl_q  <= m_rl[rl_addr];
        r_cl_q  <= m_cl[r_c];
        r_sl_q  <= m_sl[r_c];
        r_own_q <= m_own[r_c];
        r_stk_q <= m_stk[sp_m1[IDX_W-1:0]];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_sp    <= '0;
            r_rv    <= '0;
            r_cv    <= '0;
            r_ov    <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_go) begin
                        r_acc  <= '0;
                        r_last <= last_cnt[IDX_W-1:0];
                        r_ov   <= '0;
                        r_sp   <= '0;
                        r_c    <= '0;
                        r_row  <= '0;
                        r_min  <= COST_TOP;
                        r_state <= (i_npts == '0) ? S_FIN : S_IC_RD;
                    end
                end
                // column label init: least cost over all rows
                S_IC_RD: r_state <= S_IC_CMP;
                S_IC_CMP: begin
                    if (r_row == r_last) begin
                        r_row <= '0;
                        r_min <= COST_TOP;
                        if (r_c == r_last) begin
                            r_root  <= '0;
                            r_state <= S_ROW_START;
                        end else begin
                            r_c     <= r_c + 1'b1;
                            r_state <= S_IC_RD;
                        end
                    end else begin
                        r_row   <= r_row + 1'b1;
                        r_min   <= n_min;
                        r_state <= S_IC_RD;
                    end
                end
                // new root row: clear slack and visited marks
                S_ROW_START: begin
                    r_c     <= '0;
                    r_state <= S_SC;
                end
                S_SC: begin
                    if (r_c == r_last) begin
                        r_rv    <= MAX_POINTS'(1) << r_root;
                        r_cv    <= '0;
                        r_row   <= r_root;
                        r_c     <= '0;
                        r_state <= S_COL_RD;
                    end else begin
                        r_c <= r_c + 1'b1;
                    end
                end
                // column scan of the current row
                S_COL_RD: r_state <= S_COL_DIST;
                S_COL_DIST: begin
                    r_cost  <= dist_now;
                    r_state <= S_COL_EVAL;
                end
                S_COL_EVAL: begin
                    if (red_pos || r_cv[r_c]) begin
                        r_state <= S_COL_NEXT;
                    end else begin
                        r_cv[r_c] <= 1'b1;
                        if (!r_ov[r_c]) begin
                            r_ov[r_c] <= 1'b1;
                            r_state   <= S_UW;
                        end else begin
                            r_sp          <= r_sp + 1'b1;
                            r_row         <= r_own_q;
                            r_rv[r_own_q] <= 1'b1;
                            r_c           <= '0;
                            r_state       <= S_COL_RD;
                        end
                    end
                end
                S_COL_NEXT: begin
                    if (r_c == r_last) begin
                        r_state <= (r_sp == '0) ? S_DM_START : S_PF_RD;
                    end else begin
                        r_c     <= r_c + 1'b1;
                        r_state <= S_COL_RD;
                    end
                end
                // failed child: resume parent frame
                S_PF_RD: r_state <= S_PF_WAIT;
                S_PF_WAIT: begin
                    r_row   <= stk_row;
                    r_c     <= stk_col;
                    r_sp    <= sp_m1;
                    r_state <= S_COL_NEXT;
                end
                // augmenting path found: assign along the stack
                S_UW: r_state <= (r_sp == '0) ? S_ROW_NEXT : S_UW_RD;
                S_UW_RD: r_state <= S_UW_WR;
                S_UW_WR: begin
                    r_ov[stk_col] <= 1'b1;
                    r_sp          <= sp_m1;
                    r_state       <= S_UW;
                end
                // least slack over unvisited columns
                S_DM_START: begin
                    r_c     <= '0;
                    r_d     <= SLK_NONE;
                    r_state <= S_DM_RD;
                end
                S_DM_RD: r_state <= S_DM_CMP;
                S_DM_CMP: begin
                    if (!r_cv[r_c] && (r_sl_q < r_d)) begin
                        r_d <= r_sl_q;
                    end
                    if (r_c == r_last) begin
                        r_state <= S_DM_END;
                    end else begin
                        r_c     <= r_c + 1'b1;
                        r_state <= S_DM_RD;
                    end
                end
                S_DM_END: begin
                    r_c     <= '0;
                    r_state <= (r_d == SLK_NONE) ? S_ROW_NEXT : S_UP_RD;
                end
                // label update, slack reset, retry the root
                S_UP_RD: r_state <= S_UP_WR;
                S_UP_WR: begin
                    if (r_c == r_last) begin
                        r_rv    <= MAX_POINTS'(1) << r_root;
                        r_cv    <= '0;
                        r_row   <= r_root;
                        r_c     <= '0;
                        r_state <= S_COL_RD;
                    end else begin
                        r_c     <= r_c + 1'b1;
                        r_state <= S_UP_RD;
                    end
                end
                S_ROW_NEXT: begin
                    if (r_root == r_last) begin
                        r_c     <= '0;
                        r_state <= S_SUM_RD;
                    end else begin
                        r_root  <= r_root + 1'b1;
                        r_state <= S_ROW_START;
                    end
                end
                // sum of all labels
                S_SUM_RD: r_state <= S_SUM_ACC;
                S_SUM_ACC: begin
                    r_acc <= r_acc + ACC_W'(r_rl_q) + ACC_W'(r_cl_q);
                    if (r_c == r_last) begin
                        r_state <= S_FIN;
                    end else begin
                        r_c     <= r_c + 1'b1;
                        r_state <= S_SUM_RD;
                    end
                end
                S_FIN: begin
                    if (r_acc < 0) begin
                        r_total <= '0;
                    end else if (r_acc > $signed(ACC_SAT)) begin
                        r_total <= mcas_pkg::TOTAL_MAX;
                    end else begin
                        r_total <= r_acc[mcas_pkg::TOTAL_W-1:0];
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_done  = r_done;
    assign o_total = r_total;

endmodule

[design/min_cost_assignment_solver_unit.sv]
// ---------------------------------------------------------------------------
// min_cost_assignment_solver_unit: least total Manhattan distance matching
// Collects person and house points, then on a solve beat runs Kuhn-Munkres
// labeling in the core and reports the label sum and a status code.
// ---------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------
//  command  | start / busy          | i_item  (command, row, col)
//  result   | o_strobe, one cycle   | o_result (total_cost, status)
//
//  Point loads do not raise busy; busy stays low so loads stream.
//  A solve with bad counts or overflow answers in the next cycle.
//  A good solve holds busy for the core search: column label init, then
//  the depth-first search over scanned columns (shorter on a descent)
//  and label updates, all on one store port per store, then the label
//  sum; busy also covers the cycle the core result is registered.
//  Reset is synchronous, active low; the result side cannot stall.
// ---------------------------------------------------------------------------
module min_cost_assignment_solver_unit #(
    parameter int MAX_POINTS = mcas_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = mcas_pkg::COORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  mcas_pkg::t_in_beat  i_item,
    output logic                busy,
    output logic                o_strobe,
    output mcas_pkg::t_out_beat o_result
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

    logic [CNT_W-1:0]          r_pcnt, r_hcnt, wr_cnt;
    logic                      r_ovf, r_strobe;
    mcas_pkg::t_out_beat       r_result;
    logic                      accept, go, core_busy, core_done;
    logic [15:0]               row_ext, col_ext;
    logic [2*COORD_BITS-1:0]   wr_point;
    mcas_pkg::t_load_ctl       load;
    logic [mcas_pkg::TOTAL_W-1:0] core_total;

    assign accept   = start && !busy;
    assign row_ext  = {8'b0, i_item.row};
    assign col_ext  = {8'b0, i_item.col};
    assign wr_point = {row_ext[COORD_BITS-1:0], col_ext[COORD_BITS-1:0]};
    assign wr_cnt   = (i_item.command == mcas_pkg::CMD_PERSON) ? r_pcnt : r_hcnt;

    // load strobes and solve launch
    assign load.person_we = accept && (i_item.command == mcas_pkg::CMD_PERSON)
                         && (r_pcnt < CNT_MAX);
    assign load.house_we  = accept && (i_item.command == mcas_pkg::CMD_HOUSE)
                         && (r_hcnt < CNT_MAX);
    assign go = accept && (i_item.command == mcas_pkg::CMD_SOLVE)
             && !r_ovf && (r_pcnt == r_hcnt);

    mcas_core #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_wr_addr  (wr_cnt[IDX_W-1:0]),
        .i_wr_point (wr_point),
        .i_go       (go),
        .i_npts     (r_pcnt),
        .o_busy     (core_busy),
        .o_done     (core_done),
        .o_total    (core_total)
    );

    // counts, overflow flag and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt   <= '0;
            r_hcnt   <= '0;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (core_done) begin
                r_strobe            <= 1'b1;
                r_result.total_cost <= core_total;
                r_result.status     <= mcas_pkg::ST_OK;
            end
            if (accept) begin
                unique case (i_item.command)
                    mcas_pkg::CMD_PERSON: begin
                        if (r_pcnt < CNT_MAX) begin
                            r_pcnt <= r_pcnt + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    mcas_pkg::CMD_HOUSE: begin
                        if (r_hcnt < CNT_MAX) begin
                            r_hcnt <= r_hcnt + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    mcas_pkg::CMD_SOLVE: begin
                        r_pcnt <= '0;
                        r_hcnt <= '0;
                        r_ovf  <= 1'b0;
                        if (r_ovf || (r_pcnt != r_hcnt)) begin
                            r_strobe            <= 1'b1;
                            r_result.total_cost <= '0;
                            r_result.status     <= r_ovf ? mcas_pkg::ST_OVERFLOW
                                                         : mcas_pkg::ST_MISMATCH;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // hold off commands while the core result is being registered
    assign busy     = core_busy || core_done;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
